### rtl/wfgdd_pkg.sv
`default_nettype none

package wfgdd_pkg;

    localparam int NUM_TXNS = 32;
    localparam int ID_W     = 5;
    localparam int MODE_W   = 3;
    localparam int DEPTH_W  = $clog2(NUM_TXNS + 1);

    typedef logic [ID_W-1:0]     txn_id_t;
    typedef logic [NUM_TXNS-1:0] row_t;
    typedef logic [DEPTH_W-1:0]  depth_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD       = 3'd0,
        MODE_REMOVE    = 3'd1,
        MODE_CLEAR_OUT = 3'd2,
        MODE_QUERY     = 3'd3,
        MODE_DETECT    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        UPD_NONE      = 2'd0,
        UPD_ADD       = 2'd1,
        UPD_REMOVE    = 2'd2,
        UPD_CLEAR_OUT = 2'd3
    } upd_op_t;

    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GRAY  = 2'd1,
        COL_BLACK = 2'd2
    } color_t;

    typedef struct packed {
        upd_op_t op;
        txn_id_t src;
        txn_id_t dst;
    } upd_req_t;

    typedef struct packed {
        logic    busy;
        logic    done;
        logic    found;
        txn_id_t victim;
        txn_id_t node;
    } search_stat_t;

    typedef struct packed {
        logic    hit;
        txn_id_t idx;
    } first_t;

    // lowest set bit of a row
    function automatic first_t find_first(row_t v);
        first_t r;
        r = '0;
        for (int i = NUM_TXNS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r.hit = 1'b1;
                r.idx = ID_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/wfgdd_matrix.sv
`default_nettype none

module wfgdd_matrix (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wfgdd_pkg::upd_req_t upd,
    input  wire wfgdd_pkg::txn_id_t  rd_id,
    output wfgdd_pkg::row_t          row
);

    wfgdd_pkg::row_t matrix_reg [wfgdd_pkg::NUM_TXNS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wfgdd_pkg::NUM_TXNS; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else
        begin
            case (upd.op)
                wfgdd_pkg::UPD_ADD:
                begin
                    matrix_reg[upd.src][upd.dst] <= 1'b1;
                end
                wfgdd_pkg::UPD_REMOVE:
                begin
                    // row and column of the transaction
                    for (int i = 0; i < wfgdd_pkg::NUM_TXNS; i++)
                    begin
                        if (wfgdd_pkg::ID_W'(i) == upd.src)
                        begin
                            matrix_reg[i] <= '0;
                        end
                        else
                        begin
                            matrix_reg[i][upd.src] <= 1'b0;
                        end
                    end
                end
                wfgdd_pkg::UPD_CLEAR_OUT:
                begin
                    matrix_reg[upd.src] <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign row = matrix_reg[rd_id];

endmodule

`default_nettype wire

### rtl/wfgdd_search.sv
`default_nettype none

module wfgdd_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic                take,
    input  wire wfgdd_pkg::row_t     row,
    output wfgdd_pkg::search_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SCAN  = 5'b00100,
        S_POP   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam wfgdd_pkg::txn_id_t LAST_ID = wfgdd_pkg::ID_W'(wfgdd_pkg::NUM_TXNS - 1);

    state_t              state_reg, state_next;
    wfgdd_pkg::txn_id_t  start_reg, start_next;
    wfgdd_pkg::txn_id_t  node_reg, node_next;
    wfgdd_pkg::depth_t   depth_reg, depth_next;
    logic                found_reg, found_next;
    wfgdd_pkg::txn_id_t  victim_reg, victim_next;
    wfgdd_pkg::color_t   color_reg [wfgdd_pkg::NUM_TXNS];

    wfgdd_pkg::txn_id_t  stack_mem [wfgdd_pkg::NUM_TXNS];
    wfgdd_pkg::txn_id_t  stack_rd_reg;
    logic                stack_we;
    wfgdd_pkg::txn_id_t  stack_waddr;
    wfgdd_pkg::txn_id_t  stack_wdata;
    wfgdd_pkg::txn_id_t  stack_raddr;
    wfgdd_pkg::depth_t   depth_less2;

    logic                col_clear;
    logic                col_we;
    wfgdd_pkg::txn_id_t  col_idx;
    wfgdd_pkg::color_t   col_val;

    wfgdd_pkg::row_t     black_v;
    wfgdd_pkg::row_t     cand;
    wfgdd_pkg::first_t   ff;
    logic                nb_gray;
    logic                start_white;

    always_comb
    begin
        for (int i = 0; i < wfgdd_pkg::NUM_TXNS; i++)
        begin
            black_v[i] = (color_reg[i] == wfgdd_pkg::COL_BLACK);
        end
    end

    // neighbour scan: lowest non-black successor
    assign cand        = row & ~black_v;
    assign ff          = wfgdd_pkg::find_first(cand);
    assign nb_gray     = (color_reg[ff.idx] == wfgdd_pkg::COL_GRAY);
    assign start_white = (color_reg[start_reg] == wfgdd_pkg::COL_WHITE);
    assign depth_less2 = depth_reg - wfgdd_pkg::DEPTH_W'(2);

    always_comb
    begin
        state_next  = state_reg;
        start_next  = start_reg;
        node_next   = node_reg;
        depth_next  = depth_reg;
        found_next  = found_reg;
        victim_next = victim_reg;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        stack_raddr = depth_less2[wfgdd_pkg::ID_W-1:0];
        col_clear   = 1'b0;
        col_we      = 1'b0;
        col_idx     = '0;
        col_val     = wfgdd_pkg::COL_WHITE;

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    col_clear   = 1'b1;
                    start_next  = '0;
                    found_next  = 1'b0;
                    victim_next = '0;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (start_white)
                begin
                    col_we      = 1'b1;
                    col_idx     = start_reg;
                    col_val     = wfgdd_pkg::COL_GRAY;
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = start_reg;
                    node_next   = start_reg;
                    depth_next  = wfgdd_pkg::DEPTH_W'(1);
                    state_next  = S_SCAN;
                end
                else if (start_reg == LAST_ID)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    start_next = start_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (ff.hit)
                begin
                    if (nb_gray)
                    begin
                        // back edge
                        found_next  = 1'b1;
                        victim_next = (node_reg > ff.idx) ? node_reg : ff.idx;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        col_we      = 1'b1;
                        col_idx     = ff.idx;
                        col_val     = wfgdd_pkg::COL_GRAY;
                        stack_we    = 1'b1;
                        stack_waddr = depth_reg[wfgdd_pkg::ID_W-1:0];
                        stack_wdata = ff.idx;
                        node_next   = ff.idx;
                        depth_next  = depth_reg + 1'b1;
                    end
                end
                else
                begin
                    col_we     = 1'b1;
                    col_idx    = node_reg;
                    col_val    = wfgdd_pkg::COL_BLACK;
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == wfgdd_pkg::DEPTH_W'(1))
                    begin
                        if (start_reg == LAST_ID)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            start_next = start_reg + 1'b1;
                            state_next = S_START;
                        end
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                node_next  = stack_rd_reg;
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            start_reg  <= '0;
            node_reg   <= '0;
            depth_reg  <= '0;
            found_reg  <= 1'b0;
            victim_reg <= '0;
            for (int i = 0; i < wfgdd_pkg::NUM_TXNS; i++)
            begin
                color_reg[i] <= wfgdd_pkg::COL_WHITE;
            end
        end
        else
        begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            node_reg   <= node_next;
            depth_reg  <= depth_next;
            found_reg  <= found_next;
            victim_reg <= victim_next;
            if (col_clear)
            begin
                for (int i = 0; i < wfgdd_pkg::NUM_TXNS; i++)
                begin
                    color_reg[i] <= wfgdd_pkg::COL_WHITE;
                end
            end
            else if (col_we)
            begin
                color_reg[col_idx] <= col_val;
            end
        end
    end

    // gray path stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.done   = (state_reg == S_DONE);
    assign stat.found  = found_reg;
    assign stat.victim = victim_reg;
    assign stat.node   = node_reg;

endmodule

`default_nettype wire

### rtl/wait_for_graph_deadlock_detector_core.sv
// edge add, remove, clear and query: result registered in the cycle after the request
// detect: run by the single row scan unit that handles one search step per cycle
// one request at a time; taken while no search runs and the result slot is free
// reset clears the wait matrix and all visit colours; the search stack is not reset
`default_nettype none

module wait_for_graph_deadlock_detector_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              mode,
    input  wire logic [4:0]              first_id,
    input  wire logic [4:0]              second_id,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         edge_present,
    output logic                         deadlock_found,
    output logic [4:0]                   victim_id
);

    wfgdd_pkg::upd_req_t     upd;
    wfgdd_pkg::txn_id_t      rd_id;
    wfgdd_pkg::row_t         row;
    wfgdd_pkg::search_stat_t stat;

    logic out_valid_reg;
    logic edge_present_reg;
    logic deadlock_found_reg;
    logic [4:0] victim_id_reg;

    logic out_free;
    logic accept;
    logic a_ok;
    logic b_ok;
    logic is_detect;
    logic go;
    logic take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = stat.busy || !out_free;
    assign accept    = in_valid && !in_stall;
    assign a_ok      = (32'(first_id) < wfgdd_pkg::NUM_TXNS);
    assign b_ok      = (32'(second_id) < wfgdd_pkg::NUM_TXNS);
    assign is_detect = (mode == wfgdd_pkg::MODE_DETECT);
    assign go        = accept && is_detect;
    assign take      = stat.done && out_free;
    assign rd_id     = stat.busy ? stat.node : first_id;

    always_comb
    begin
        upd.op  = wfgdd_pkg::UPD_NONE;
        upd.src = first_id;
        upd.dst = second_id;
        if (accept)
        begin
            case (mode)
                wfgdd_pkg::MODE_ADD:
                begin
                    if (a_ok && b_ok)
                    begin
                        upd.op = wfgdd_pkg::UPD_ADD;
                    end
                end
                wfgdd_pkg::MODE_REMOVE:
                begin
                    if (a_ok)
                    begin
                        upd.op = wfgdd_pkg::UPD_REMOVE;
                    end
                end
                wfgdd_pkg::MODE_CLEAR_OUT:
                begin
                    if (a_ok)
                    begin
                        upd.op = wfgdd_pkg::UPD_CLEAR_OUT;
                    end
                end
                default:
                begin
                    upd.op = wfgdd_pkg::UPD_NONE;
                end
            endcase
        end
    end

    wfgdd_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .rd_id (rd_id),
        .row   (row)
    );

    wfgdd_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .take  (take),
        .row   (row),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !is_detect) || take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_detect)
        begin
            edge_present_reg   <= (mode == wfgdd_pkg::MODE_QUERY) && a_ok && b_ok
                                  && row[second_id];
            deadlock_found_reg <= 1'b0;
            victim_id_reg      <= '0;
        end
        else if (take)
        begin
            edge_present_reg   <= 1'b0;
            deadlock_found_reg <= stat.found;
            victim_id_reg      <= stat.victim;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_present   = edge_present_reg;
    assign deadlock_found = deadlock_found_reg;
    assign victim_id      = victim_id_reg;

endmodule

`default_nettype wire
